/* hdl/mh2_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_pkg
// Shared constants, types and helpers of the streaming MurmurHash2 block.
// ----------------------------------------------------------------------------
package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  localparam logic [2:0] BYTES_FULL = 3'd4;
  localparam logic [2:0] BYTES_NONE = 3'd0;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MK1  = 7'b0000010,
    S_MK2  = 7'b0000100,
    S_MA   = 7'b0001000,
    S_WB   = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  // mask for a partial word of 1 to 3 bytes
  function automatic logic [31:0] tail_mask(input logic [2:0] n);
    logic [31:0] m;
    m = 32'h00ffffff;
    if (n == 3'd1) begin
      m = 32'h000000ff;
    end else if (n == 3'd2) begin
      m = 32'h0000ffff;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* hdl/mh2_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_mul
// Shared multiplier: low 32 bits of operand times the mix constant, registered.
// ----------------------------------------------------------------------------
module mh2_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  output logic      [31:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * mh2_pkg::MIX_MUL;
    end
  end

endmodule
`default_nettype wire

/* hdl/murmur2_stream_hash.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur2_stream_hash
// Streaming 32-bit MurmurHash2 over little-endian words, one shared multiplier.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid/in_ready    word, valid_bytes, first, last, total_len
//   out      out_valid/out_ready  digest
//   cfg      cfg_we               cfg_wdata (seed)
//
// One item at a time. Full word: accept, three products through the one
// multiplier and write-back; partial word: accept, one product, write-back;
// empty: accept only. A last item adds the finalize product and result load.
// Reset is synchronous; seed and running hash clear to zero.
// A stalled output holds the block in its final state until the result moves.
module murmur2_stream_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        first,
  input  wire logic        last,
  input  wire logic [30:0] total_len,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] digest
);

  mh2_pkg::state_t state, state_next;

  logic [31:0] seed;
  logic [31:0] running_hash;
  logic [31:0] wreg;
  logic        blk;
  logic        last_q;

  logic [2:0]  n_sat;
  logic [31:0] acc0;
  logic        accept;

  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_p;
  logic [31:0] fin_val;
  logic        out_load;

  assign in_ready = (state == mh2_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign n_sat    = (valid_bytes > mh2_pkg::BYTES_FULL) ? mh2_pkg::BYTES_FULL : valid_bytes;
  assign acc0     = first ? (seed ^ {1'b0, total_len}) : running_hash;
  assign fin_val  = mul_p ^ (mul_p >> mh2_pkg::FIN_SHIFT_B);
  assign out_load = (state == mh2_pkg::S_OUT) && (!out_valid || out_ready);

  always_comb begin
    mul_en = 1'b1;
    mul_a  = wreg;
    unique case (state)
      mh2_pkg::S_MK1: mul_a = wreg;
      mh2_pkg::S_MK2: mul_a = mul_p ^ (mul_p >> mh2_pkg::MIX_SHIFT);
      mh2_pkg::S_MA:  mul_a = running_hash;
      mh2_pkg::S_FIN: mul_a = running_hash ^ (running_hash >> mh2_pkg::FIN_SHIFT_A);
      mh2_pkg::S_IDLE,
      mh2_pkg::S_WB,
      mh2_pkg::S_OUT: mul_en = 1'b0;
      default:        mul_en = 1'b0;
    endcase
  end

  mh2_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .p   (mul_p)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mh2_pkg::S_IDLE: begin
        if (accept) begin
          if (n_sat == mh2_pkg::BYTES_FULL) begin
            state_next = mh2_pkg::S_MK1;
          end else if (n_sat != mh2_pkg::BYTES_NONE) begin
            state_next = mh2_pkg::S_MA;
          end else if (last) begin
            state_next = mh2_pkg::S_FIN;
          end
        end
      end
      mh2_pkg::S_MK1: state_next = mh2_pkg::S_MK2;
      mh2_pkg::S_MK2: state_next = mh2_pkg::S_MA;
      mh2_pkg::S_MA:  state_next = mh2_pkg::S_WB;
      mh2_pkg::S_WB:  state_next = last_q ? mh2_pkg::S_FIN : mh2_pkg::S_IDLE;
      mh2_pkg::S_FIN: state_next = mh2_pkg::S_OUT;
      mh2_pkg::S_OUT: state_next = out_load ? mh2_pkg::S_IDLE : mh2_pkg::S_OUT;
      default:        state_next = mh2_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mh2_pkg::S_IDLE;
      seed         <= '0;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      if (accept) begin
        // tail bytes are folded in before the single multiply
        if (n_sat != mh2_pkg::BYTES_FULL && n_sat != mh2_pkg::BYTES_NONE) begin
          running_hash <= acc0 ^ (word & mh2_pkg::tail_mask(n_sat));
        end else begin
          running_hash <= acc0;
        end
      end else if (state == mh2_pkg::S_WB) begin
        running_hash <= mul_p ^ wreg;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wreg   <= word;
      blk    <= (n_sat == mh2_pkg::BYTES_FULL);
      last_q <= last;
    end else if (state == mh2_pkg::S_MA) begin
      // keep the mixed key for the block path, nothing for the tail path
      wreg <= blk ? mul_p : '0;
    end
    if (out_load) begin
      digest <= fin_val;
    end
  end

`ifndef SYNTHESIS
  a_out_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == mh2_pkg::S_OUT))
    else $error("result appeared outside the final state");

  a_empty_last_fin: assert property (@(posedge clk) disable iff (rst)
    (accept && last && valid_bytes == mh2_pkg::BYTES_NONE) |=> state == mh2_pkg::S_FIN)
    else $error("empty last item did not go to finalize");

  a_wb_ready: assert property (@(posedge clk) disable iff (rst)
    (state == mh2_pkg::S_WB && !last_q) |=> in_ready)
    else $error("not ready after a non-last item");
`endif

endmodule
`default_nettype wire

/* verif/mh2_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_digest_checker
// Watches the seed port and both item channels of the streaming MurmurHash2
// block, keeps its own running hash and seed, queues the digest each last item
// should produce and compares every digest leaving the block against it.
// ----------------------------------------------------------------------------
module mh2_digest_checker
  import mh2_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] word,
  input  logic [2:0]  valid_bytes,
  input  logic        first,
  input  logic        last,
  input  logic [30:0] total_len,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest,
  output int          errors,
  output int          pending,
  output int          digests_checked
);

  logic [31:0] seed_q;
  logic [31:0] hash_q;
  logic [31:0] due_digests[$];
  int          err_cnt = 0;
  int          checked_cnt = 0;

  function automatic logic [31:0] mix_full_word(input logic [31:0] acc,
                                                input logic [31:0] w);
    logic [31:0] k;
    k = w * MIX_MUL;
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL;
    return (acc * MIX_MUL) ^ k;
  endfunction

  function automatic logic [31:0] mix_partial_word(input logic [31:0] acc,
                                                   input logic [31:0] w,
                                                   input logic [2:0]  n);
    logic [31:0] keep;
    case (n)
      3'd1: keep = 32'h0000_00ff;
      3'd2: keep = 32'h0000_ffff;
      default: keep = 32'h00ff_ffff;
    endcase
    return (acc ^ (w & keep)) * MIX_MUL;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] acc);
    logic [31:0] h;
    h = acc ^ (acc >> FIN_SHIFT_A);
    h = h * MIX_MUL;
    h = h ^ (h >> FIN_SHIFT_B);
    return h;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    logic [31:0] acc;
    logic [2:0]  nb;
    logic [31:0] want;
    if (rst) begin
      seed_q = '0;
      hash_q = '0;
      due_digests.delete();
    end else begin
      if (cfg_we) begin
        seed_q = cfg_wdata;
      end
      // outgoing digest first: it can never come from an item taken this edge
      if (out_valid && out_ready) begin
        if (due_digests.size() == 0) begin
          report_mismatch($sformatf("digest %08h with no item waiting for it", digest));
        end else begin
          want = due_digests.pop_front();
          checked_cnt++;
          if (digest !== want) begin
            report_mismatch($sformatf("digest %08h, predicted %08h", digest, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        nb  = (valid_bytes > BYTES_FULL) ? BYTES_FULL : valid_bytes;
        acc = first ? (seed_q ^ {1'b0, total_len}) : hash_q;
        if (nb == BYTES_FULL) begin
          acc = mix_full_word(acc, word);
        end else if (nb != BYTES_NONE) begin
          acc = mix_partial_word(acc, word, nb);
        end
        // finalization leaves the running hash untouched
        hash_q = acc;
        if (last) begin
          due_digests = {due_digests, avalanche(acc)};
        end
      end
    end
    errors          <= err_cnt;
    pending         <= due_digests.size();
    digests_checked <= checked_cnt;
  end

endmodule

/* verif/tb_murmur2_stream_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur2_stream_hash
// Drives word items and seed writes into the streaming MurmurHash2 block with
// random idle cycles on both channels: directed corner messages first, then
// random well-formed messages mixed with malformed bursts. The checker beside
// the block predicts and compares every digest.
// ----------------------------------------------------------------------------
module tb_murmur2_stream_hash;
  import mh2_pkg::*;

  localparam int RANDOM_ITEMS  = 550;
  localparam int PHASE_ITEMS   = 92;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic [31:0] word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        first = 1'b0;
  logic        last = 1'b0;
  logic [30:0] total_len = '0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [31:0] digest;

  int errors;
  int pending;
  int digests_checked;
  int cycle_count = 0;
  int items_sent = 0;
  int messages_sent = 0;
  int seed_writes = 0;
  int holds_done = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_req = 1'b0;

  murmur2_stream_hash u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .word        (word),
    .valid_bytes (valid_bytes),
    .first       (first),
    .last        (last),
    .total_len   (total_len),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest      (digest)
  );

  mh2_digest_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .word            (word),
    .valid_bytes     (valid_bytes),
    .first           (first),
    .last            (last),
    .total_len       (total_len),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .digest          (digest),
    .errors          (errors),
    .pending         (pending),
    .digests_checked (digests_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls per digest, plus one long hold on request
  initial begin : digest_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // leaves in_valid high after the item is taken; the next call or settle()
  // drives it in the same step
  task automatic send_item(input logic [31:0] w, input logic [2:0] nb,
                           input logic f, input logic l, input logic [30:0] len);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    word        <= w;
    valid_bytes <= nb;
    first       <= f;
    last        <= l;
    total_len   <= len;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // pending is registered behind the channels, hence the leading edge
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    seed_writes++;
  endtask

  task automatic send_message();
    int          kind;
    int          nfull;
    int          tail;
    int          nitems;
    logic [30:0] len;
    logic [2:0]  nb;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      nfull  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
      tail   = $urandom_range(0, 3);
      len    = 31'(4 * nfull + tail);
      if ($urandom_range(0, 7) == 0) begin
        len = 31'($urandom());
      end
      // a trailing empty item closes some messages with no bytes in it
      nitems = nfull;
      if (tail != 0 || nfull == 0 || $urandom_range(0, 3) == 0) begin
        nitems++;
      end
      for (int i = 0; i < nitems; i++) begin
        if (i < nfull) begin
          nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : BYTES_FULL;
        end else begin
          nb = 3'(tail);
        end
        send_item($urandom(), nb, i == 0, i == nitems - 1,
                  (i == 0) ? len : 31'($urandom()));
      end
    end else begin
      // malformed burst: every field random
      nitems = $urandom_range(1, 4);
      for (int i = 0; i < nitems; i++) begin
        send_item($urandom(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 31'($urandom()));
      end
    end
    messages_sent++;
  endtask

  initial begin : stimulus
    int target;
    int phase_end;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty messages at both length extremes, one-word ones, seed at reset
    send_item(32'h1234_5678, BYTES_NONE, 1'b1, 1'b1, 31'h0);
    send_item(32'hffff_ffff, BYTES_NONE, 1'b1, 1'b1, 31'h7fff_ffff);
    send_item(32'hffff_ffff, BYTES_FULL, 1'b1, 1'b1, 31'd4);
    send_item(32'h0000_0000, BYTES_FULL, 1'b1, 1'b1, 31'd4);
    write_seed(32'hffff_ffff);
    // tail only; bytes above the valid count must be masked
    send_item(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 31'd1);
    send_item(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 31'd2);
    send_item(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 31'd3);
    // last item carrying no bytes
    send_item(32'hdead_beef, BYTES_FULL, 1'b1, 1'b0, 31'd4);
    send_item(32'hcafe_f00d, BYTES_NONE, 1'b0, 1'b1, 31'h5555_5555);
    // byte counts 5..7 act as a full word
    send_item(32'h0102_0304, 3'd5, 1'b1, 1'b0, 31'd12);
    send_item(32'h0506_0708, 3'd6, 1'b0, 1'b0, 31'h2aaa_aaaa);
    send_item(32'h090a_0b0c, 3'd7, 1'b0, 1'b1, 31'd0);
    // partial word in the middle of a message
    send_item(32'h8000_0001, 3'd2, 1'b1, 1'b0, 31'd6);
    send_item(32'h7fff_fffe, BYTES_FULL, 1'b0, 1'b1, 31'd0);
    // no first: carries on from the unfinalized hash of the previous message
    send_item(32'ha5a5_a5a5, BYTES_FULL, 1'b0, 1'b1, 31'd0);
    send_item(32'h5a5a_5a5a, BYTES_FULL, 1'b0, 1'b0, 31'd0);
    send_item(32'h00c0_ffee, 3'd3, 1'b0, 1'b1, 31'd0);
    // first again before the message ended restarts from the seed
    send_item(32'h1111_1111, BYTES_FULL, 1'b1, 1'b0, 31'd8);
    send_item(32'h2222_2222, BYTES_FULL, 1'b1, 1'b1, 31'd4);

    target = items_sent + RANDOM_ITEMS;
    for (int p = 0; items_sent < target; p++) begin
      case (p % 4)
        0: write_seed($urandom());
        1: write_seed(32'h0000_0000);
        2: write_seed(32'hffff_ffff);
        default: ;
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      // the sender keeps going while the sink holds off, so the block backs up
      if (p == 1) begin
        hold_req = 1'b1;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < target) begin
        send_message();
      end
    end
    settle();

    $display("run: %0d items in %0d messages and bursts, %0d digests checked, %0d seed writes",
             items_sent, messages_sent, digests_checked, seed_writes);
    $display("run: corner messages, random and malformed streams, %0d long output holds",
             holds_done);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* murmur2_stream_hash.f */
hdl/mh2_pkg.sv
hdl/mh2_mul.sv
hdl/murmur2_stream_hash.sv
verif/mh2_digest_checker.sv
verif/tb_murmur2_stream_hash.sv
